// ===== src/sno_pkg.sv =====
`default_nettype none

package sno_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PHASE_STEP = 3'd0,
        CFG_AMPLITUDE  = 3'd1,
        CFG_ENABLE     = 3'd2,
        CFG_BYPASS     = 3'd3
    } t_cfg_reg;

    // input item operation codes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    localparam int PHASE_BITS  = 32;
    localparam int AMP_BITS    = 16;
    localparam int OUT_BITS    = 16;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RST = 32'd42852281;
    localparam logic [AMP_BITS-1:0]   AMPLITUDE_RST  = 16'd32768;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // quarter-wave entry k: Taylor series of sin in Q30, scaled to the table peak
    function automatic logic [63:0] quarter_entry(input int k, input int addr_bits,
                                                  input int sample_bits);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] t5;
        logic [63:0] t6;
        logic [63:0] peak;
        logic [63:0] mag;
        longint      sum;
        theta = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (addr_bits + 1);
        x2    = (theta * theta) >> 30;
        t1    = ((theta * x2) >> 30) / 64'd6;
        t2    = ((t1 * x2) >> 30) / 64'd20;
        t3    = ((t2 * x2) >> 30) / 64'd42;
        t4    = ((t3 * x2) >> 30) / 64'd72;
        t5    = ((t4 * x2) >> 30) / 64'd110;
        t6    = ((t5 * x2) >> 30) / 64'd156;
        sum   = longint'(theta) - longint'(t1) + longint'(t2) - longint'(t3)
              + longint'(t4) - longint'(t5) + longint'(t6);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        mag  = 64'(sum);
        peak = (64'd1 << (sample_bits - 1)) - 64'd1;
        return (mag * peak + (64'd1 << 29)) >> 30;
    endfunction

endpackage

`default_nettype wire

// ===== src/sno_sine_rom.sv =====
`default_nettype none

module sno_sine_rom #(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [ADDR_BITS-1:0]   i_addr,
    output logic      [SAMPLE_BITS-2:0] o_data
);
    import sno_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    // quarter-wave table, filled at elaboration
    logic [SAMPLE_BITS-2:0] w_rom [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_rom
        localparam logic [63:0] ENTRY = quarter_entry(k, ADDR_BITS, SAMPLE_BITS);
        assign w_rom[k] = ENTRY[SAMPLE_BITS-2:0];
    end

    // registered read
    logic [SAMPLE_BITS-2:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== src/sine_oscillator_nco.sv =====
`default_nettype none

// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+--------------------------------
// input    | in        | i_in_valid / o_in_ready      | i_op, i_phase_value
// output   | out       | o_out_valid / i_out_ready    | o_sample, o_phase_now
// config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// one item per clock while the output accepts; a tick result is registered in turn through
// the table read, the gain multiply and the rounding into the output register
// the phase accumulator is updated in the cycle the item is taken; a phase load gives no result
// synchronous active-low reset clears the phase and all valid flags and loads the register defaults
// each stage holds while the stage after it is full and stalled, bubbles close up

module sine_oscillator_nco #(
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_op,
    input  wire logic [sno_pkg::PHASE_BITS-1:0]      i_phase_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [sno_pkg::OUT_BITS-1:0]      o_sample,
    output logic      [sno_pkg::PHASE_BITS-1:0]      o_phase_now,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sno_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [sno_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import sno_pkg::*;

    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + AMP_BITS;
    localparam int RND_BITS  = OUT_BITS + 1;

    // configuration registers
    logic [PHASE_BITS-1:0] r_phase_step;
    logic [AMP_BITS-1:0]   r_amplitude;
    logic                  r_enable;
    logic                  r_bypass;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= PHASE_STEP_RST;
            r_amplitude  <= AMPLITUDE_RST;
            r_enable     <= 1'b0;
            r_bypass     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PHASE_STEP: r_phase_step <= i_cfg_data;
                CFG_AMPLITUDE:  r_amplitude  <= i_cfg_data[AMP_BITS-1:0];
                CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                CFG_BYPASS:     r_bypass     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage handshakes
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;
    logic w_s1_ready;
    logic w_s2_ready;
    logic w_out_ready;

    assign w_out_ready = !r_out_valid || i_out_ready;
    assign w_s2_ready  = !r_s2_valid || w_out_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;
    assign o_in_ready  = w_s1_ready;

    logic w_accept;
    logic w_tick;
    logic w_active;

    assign w_accept = i_in_valid && w_s1_ready;
    assign w_tick   = w_accept && (t_op'(i_op) == OP_TICK);
    assign w_active = r_enable && !r_bypass;

    // phase accumulator
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            if (t_op'(i_op) == OP_LOAD) begin
                n_phase = i_phase_value;
            end else if (w_active) begin
                n_phase = r_phase + r_phase_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

    // quarter-wave address: mirror in odd quadrants
    logic [TABLE_ADDR_BITS-1:0] w_frac;
    logic [TABLE_ADDR_BITS-1:0] w_addr;
    logic [MAG_BITS-1:0]        w_rom_data;

    assign w_frac = r_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign w_addr = r_phase[PHASE_BITS-2] ? ~w_frac : w_frac;

    sno_sine_rom #(
        .ADDR_BITS   (TABLE_ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (w_s1_ready),
        .i_addr (w_addr),
        .o_data (w_rom_data)
    );

    // stage 1: table read
    logic                  r_s1_active;
    logic                  r_s1_neg;
    logic [PHASE_BITS-1:0] r_s1_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_active <= w_active;
            r_s1_neg    <= r_phase[PHASE_BITS-1];
            r_s1_phase  <= n_phase;
        end
    end

    // stage 2: gain multiply, silent ticks multiply zero
    logic [MAG_BITS-1:0]   w_mag;
    logic [PROD_BITS-1:0]  r_s2_prod;
    logic                  r_s2_neg;
    logic [PHASE_BITS-1:0] r_s2_phase;

    assign w_mag = r_s1_active ? w_rom_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready) begin
            r_s2_prod  <= PROD_BITS'(w_mag) * PROD_BITS'(r_amplitude);
            r_s2_neg   <= r_s1_neg;
            r_s2_phase <= r_s1_phase;
        end
    end

    // stage 3: round half away from zero, saturate, apply sign
    logic [PROD_BITS:0]    w_rnd_sum;
    logic [RND_BITS-1:0]   w_rnd;
    logic [RND_BITS-1:0]   w_clip;
    logic [RND_BITS-1:0]   w_signed;
    logic [OUT_BITS-1:0]   r_out_sample;
    logic [PHASE_BITS-1:0] r_out_phase;

    assign w_rnd_sum = {1'b0, r_s2_prod} + ((PROD_BITS+1)'(1) << (SAMPLE_BITS - 2));
    assign w_rnd     = RND_BITS'(w_rnd_sum >> MAG_BITS);

    always_comb begin
        if (r_s2_neg) begin
            w_clip   = (w_rnd > RND_BITS'(32768)) ? RND_BITS'(32768) : w_rnd;
            w_signed = RND_BITS'(0) - w_clip;
        end else begin
            w_clip   = (w_rnd > RND_BITS'(32767)) ? RND_BITS'(32767) : w_rnd;
            w_signed = w_clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            r_out_sample <= w_signed[OUT_BITS-1:0];
            r_out_phase  <= r_s2_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_phase_now = r_out_phase;

    // phase load takes effect in the next cycle
    a_load_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_op'(i_op) == OP_LOAD)) |=> (r_phase == $past(i_phase_value)))
        else $error("phase load not applied");

    // a silent tick keeps the phase
    a_silent_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && !w_active) |=> (r_phase == $past(r_phase)))
        else $error("phase moved on a silent tick");

    // a silent tick reaching the multiplier gives a zero product
    a_silent_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_active && w_s2_ready) |=> (r_s2_prod == '0))
        else $error("silent tick produced a nonzero product");

    // a stalled first stage keeps its item
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s2_ready) |=> (r_s1_valid && $stable(r_s1_phase)))
        else $error("stage one lost an item under stall");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sno_pkg::*;

    localparam int TBL_BITS    = 10;
    localparam int SMP_BITS    = 16;
    localparam int TBL_SIZE    = 1 << TBL_BITS;
    localparam int LATENCY     = 3;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;

    // indexes past the last register, written to show they are ignored
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [OUT_BITS-1:0]   sample;
        logic [PHASE_BITS-1:0] phase;
    } t_sample_due;

    // block ports
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    t_op                        i_op = OP_TICK;
    logic [PHASE_BITS-1:0]      i_phase_value = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [OUT_BITS-1:0] o_sample;
    logic [PHASE_BITS-1:0]      o_phase_now;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data = '0;

    // predicted oscillator state and registers
    logic [PHASE_BITS-1:0] osc_phase = '0;
    logic [PHASE_BITS-1:0] osc_step = PHASE_STEP_RST;
    logic [AMP_BITS-1:0]   osc_gain = AMPLITUDE_RST;
    logic                  osc_enable = 1'b0;
    logic                  osc_bypass = 1'b0;
    logic [SMP_BITS-1:0]   quarter_sine [0:TBL_SIZE-1];

    t_sample_due samples_due[$];
    int          error_count = 0;
    int          cycle_count = 0;

    // sender burst state
    int burst_left = 0;
    bit no_gaps = 1'b0;

    // receiver hold-off requests
    int hold_req_count = 0;

    sine_oscillator_nco #(
        .TABLE_ADDR_BITS(TBL_BITS),
        .SAMPLE_BITS    (SMP_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_phase_value(i_phase_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample     (o_sample),
        .o_phase_now  (o_phase_now),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // quarter-wave entry from a Taylor series of sin in Q30
    function automatic logic [SMP_BITS-1:0] sine_entry(input int k);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] peak;
        longint      acc;
        theta = (HALF_PI_Q30 * 64'(2 * k + 1)) >> (TBL_BITS + 1);
        x2    = (theta * theta) >> 30;
        term  = theta;
        acc   = longint'(theta);
        for (int n = 1; n <= 6; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(ONE_Q30)) begin
            acc = longint'(ONE_Q30);
        end
        peak = (64'd1 << (SMP_BITS - 1)) - 64'd1;
        return SMP_BITS'((64'(acc) * peak + (64'd1 << 29)) >> 30);
    endfunction

    // table lookup by quadrant, gain, rounding half away from zero, saturation
    function automatic logic [OUT_BITS-1:0] scaled_sine(input logic [PHASE_BITS-1:0] ph);
        logic [1:0]          quad;
        logic [TBL_BITS-1:0] addr;
        logic [63:0]         mag;
        logic [63:0]         prod;
        logic [63:0]         r;
        quad = ph[31:30];
        addr = quad[0] ? ~ph[29 -: TBL_BITS] : ph[29 -: TBL_BITS];
        mag  = 64'(quarter_sine[addr]);
        prod = mag * 64'(osc_gain) * 64'd32768;
        r    = (prod + (64'd1 << (SMP_BITS + 13))) >> (SMP_BITS + 14);
        if (quad[1]) begin
            if (r > 64'd32768) begin
                r = 64'd32768;
            end
            return OUT_BITS'(64'd0 - r);
        end
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return OUT_BITS'(r);
    endfunction

    // predictor: follows every accepted register write and input transaction
    always @(posedge i_clk) begin
        t_sample_due due;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PHASE_STEP: osc_step   = i_cfg_data;
                    CFG_AMPLITUDE:  osc_gain   = i_cfg_data[AMP_BITS-1:0];
                    CFG_ENABLE:     osc_enable = i_cfg_data[0];
                    CFG_BYPASS:     osc_bypass = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (i_op == OP_LOAD) begin
                    osc_phase = i_phase_value;
                end else begin
                    due.sample = '0;
                    if (osc_enable && !osc_bypass) begin
                        due.sample = scaled_sine(osc_phase);
                        osc_phase  = osc_phase + osc_step;
                    end
                    due.phase = osc_phase;
                    samples_due.push_back(due);
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_sample_due head;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (samples_due.size() == 0) begin
                $display("%0t: unexpected result, sample %0d phase %h",
                         $time, o_sample, o_phase_now);
                error_count++;
            end else begin
                head = samples_due.pop_front();
                if (o_sample !== head.sample) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, $signed(head.sample), o_sample);
                    error_count++;
                end
                if (o_phase_now !== head.phase) begin
                    $display("%0t: phase mismatch, expected %h, actual %h",
                             $time, head.phase, o_phase_now);
                    error_count++;
                end
            end
        end
    end

    // receiver: random 32-bit stall pattern, reloaded once used up, long hold-off on request
    always @(posedge i_clk) begin
        int          hold_seen;
        int          hold_left;
        int          pattern_pos;
        logic [31:0] stall_pattern;
        if (hold_req_count != hold_seen) begin
            hold_seen = hold_req_count;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (pattern_pos == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '1;
                    1:       stall_pattern = $urandom;
                    2:       stall_pattern = $urandom | $urandom;
                    default: stall_pattern = $urandom & $urandom;
                endcase
            end
            i_out_ready <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 32;
        end
    end

    // offer one input transaction, with a random gap at the start of each burst
    task automatic send_item(input t_op op, input logic [PHASE_BITS-1:0] ph);
        int gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if ($urandom_range(0, 15) == 0 && !no_gaps) begin
                gap = $urandom_range(10, 30);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_phase_value <= ph;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        burst_left--;
    endtask

    // stop offering and wait until every sample has come out and the pipe is empty
    // the first edge lets the predictor log the last transaction
    task automatic settle_block();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (samples_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // one register write transaction, then valid is dropped before returning
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // silent ticks out of reset, then the reset step and gain once started
    task automatic test_reset_defaults();
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '1);
        settle_block();
        write_reg(CFG_ENABLE, 32'h0000_0001);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        settle_block();
    endtask

    // full gain saturation, quadrant edges, wrap of the accumulator, zero gain
    task automatic test_extremes();
        write_reg(CFG_AMPLITUDE, 32'h0000_FFFF);
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 32'h3FFF_FFFF);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        send_item(OP_LOAD, 32'hC000_0000);
        send_item(OP_TICK, '0);
        send_item(OP_LOAD, 32'hFFFF_FFFF);
        send_item(OP_TICK, '0);
        settle_block();
        write_reg(CFG_AMPLITUDE, 32'hFFFF_0000);
        send_item(OP_TICK, '0);
        settle_block();
    endtask

    // bypass and disable hold the phase, loads still land, spare indexes do nothing
    task automatic test_hold_modes();
        write_reg(CFG_BYPASS, 32'hFFFF_FFFF);
        send_item(OP_TICK, '0);
        send_item(OP_LOAD, 32'h8000_0000);
        send_item(OP_TICK, '0);
        settle_block();
        write_reg(CFG_BYPASS, 32'hFFFF_FFFE);
        write_reg(CFG_AMPLITUDE, 32'h0000_8000);
        write_reg(CFG_PHASE_STEP, 32'h0000_0000);
        send_item(OP_TICK, '0);
        send_item(OP_TICK, '0);
        settle_block();
        write_reg(CFG_ENABLE, 32'h0000_0000);
        send_item(OP_TICK, '0);
        settle_block();
        write_reg(CFG_INDEX_BITS'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)), $urandom);
        write_reg(CFG_ENABLE, 32'h8000_0001);
        send_item(OP_TICK, '0);
        settle_block();
    endtask

    // random settings per round, mostly ticks with some phase loads
    task automatic test_random_run();
        logic [PHASE_BITS-1:0] ph;
        logic [AMP_BITS-1:0]   gain;
        int                    count;
        for (int round = 0; round < 9; round++) begin
            case ($urandom_range(0, 3))
                0:       ph = '0;
                1:       ph = '1;
                2:       ph = $urandom_range(1, 32'h00FF_FFFF);
                default: ph = $urandom;
            endcase
            write_reg(CFG_PHASE_STEP, ph);
            case ($urandom_range(0, 4))
                0:       gain = '0;
                1:       gain = '1;
                2:       gain = 16'h8000;
                default: gain = 16'($urandom);
            endcase
            write_reg(CFG_AMPLITUDE, {16'($urandom), gain});
            write_reg(CFG_ENABLE, {31'($urandom), 1'($urandom_range(0, 5) != 0)});
            write_reg(CFG_BYPASS, {31'($urandom), 1'($urandom_range(0, 5) == 0)});
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_INDEX_BITS'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                          $urandom);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            count = $urandom_range(70, 110);
            for (int n = 0; n < count; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // loads: random phase or a quadrant edge
                    ph = $urandom;
                    if ($urandom_range(0, 2) == 0) begin
                        ph = {2'($urandom),
                              ($urandom_range(0, 1) != 0) ? 30'h0000_0000 : 30'h3FFF_FFFF};
                    end
                    send_item(OP_LOAD, ph);
                end else begin
                    send_item(OP_TICK, $urandom);
                end
            end
            settle_block();
        end
        no_gaps = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_stall();
        write_reg(CFG_ENABLE, 32'h0000_0001);
        write_reg(CFG_BYPASS, 32'h0000_0000);
        write_reg(CFG_PHASE_STEP, $urandom);
        no_gaps = 1'b1;
        hold_req_count++;
        for (int n = 0; n < 48; n++) begin
            send_item(OP_TICK, $urandom);
        end
        settle_block();
        no_gaps = 1'b0;
    endtask

    // main sequence
    initial begin
        for (int k = 0; k < TBL_SIZE; k++) begin
            quarter_sine[k] = sine_entry(k);
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extremes();
        test_hold_modes();
        test_random_run();
        test_output_stall();

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
